/* src/srg_pkg.sv */
// Shared types, constants and the control program of the subtractive generator.
// No dependencies; every other file imports this package.
package srg_pkg;

    localparam int unsigned SEED_W  = 29;
    localparam int unsigned VALUE_W = 30;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CNT_W   = 8;

    localparam logic [VALUE_W-1:0] MOD_BIG   = 30'd1000000000;
    localparam logic [SEED_W-1:0]  SEED_BASE = 29'd161803398;
    localparam int unsigned        TABLE_LEN = 55;
    localparam logic [IDX_W-1:0]   LAST_IDX  = 6'(TABLE_LEN - 1);
    localparam logic [IDX_W-1:0]   LAG_START = 6'd31;
    localparam logic [IDX_W-1:0]   STRIDE    = 6'd21;
    localparam logic [CNT_W-1:0]   SCAT_LAST = 8'(TABLE_LEN - 2);
    localparam logic [CNT_W-1:0]   WARM_LAST = 8'(4 * TABLE_LEN - 1);

    // Program steps
    typedef enum logic [3:0] {
        STEP_WAIT       = 4'd0,
        STEP_CHECK      = 4'd1,
        STEP_SCAT_INIT  = 4'd2,
        STEP_SCAT       = 4'd3,
        STEP_WARM_INIT  = 4'd4,
        STEP_WARM_RD    = 4'd5,
        STEP_WARM_WR    = 4'd6,
        STEP_RESEED_END = 4'd7,
        STEP_DRAW_ADV   = 4'd8,
        STEP_DRAW_RD    = 4'd9,
        STEP_OUT_WAIT   = 4'd10,
        STEP_DRAW_WR    = 4'd11
    } step_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SCAT_INIT,
        OP_SCAT,
        OP_WARM_INIT,
        OP_WARM_RD,
        OP_WARM_WR,
        OP_RESEED_END,
        OP_DRAW_ADV,
        OP_DRAW_RD,
        OP_DRAW_WR
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_NO_RESEED,
        C_CNT_NZ,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic reseed;
        logic cnt_nz;
        logic out_busy;
    } status_t;

    // Control store: one word per step
    function automatic ctrl_t ucode_word(input step_t step);
        ctrl_t w;
        begin
            case (step)
                STEP_WAIT:       w = '{OP_ACCEPT,     C_NO_ACCEPT, STEP_WAIT};
                STEP_CHECK:      w = '{OP_NOP,        C_NO_RESEED, STEP_DRAW_ADV};
                STEP_SCAT_INIT:  w = '{OP_SCAT_INIT,  C_NEVER,     STEP_WAIT};
                STEP_SCAT:       w = '{OP_SCAT,       C_CNT_NZ,    STEP_SCAT};
                STEP_WARM_INIT:  w = '{OP_WARM_INIT,  C_NEVER,     STEP_WAIT};
                STEP_WARM_RD:    w = '{OP_WARM_RD,    C_NEVER,     STEP_WAIT};
                STEP_WARM_WR:    w = '{OP_WARM_WR,    C_CNT_NZ,    STEP_WARM_RD};
                STEP_RESEED_END: w = '{OP_RESEED_END, C_NEVER,     STEP_WAIT};
                STEP_DRAW_ADV:   w = '{OP_DRAW_ADV,   C_NEVER,     STEP_WAIT};
                STEP_DRAW_RD:    w = '{OP_DRAW_RD,    C_NEVER,     STEP_WAIT};
                STEP_OUT_WAIT:   w = '{OP_NOP,        C_OUT_BUSY,  STEP_OUT_WAIT};
                STEP_DRAW_WR:    w = '{OP_DRAW_WR,    C_ALWAYS,    STEP_WAIT};
                default:         w = '{OP_NOP,        C_ALWAYS,    STEP_WAIT};
            endcase
            return w;
        end
    endfunction

    // (a - b) mod 10^9 for a, b below 10^9
    function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] wide;
        begin
            if (a >= b) begin
                wide = {1'b0, a} - {1'b0, b};
            end else begin
                wide = {1'b0, a} + {1'b0, MOD_BIG} - {1'b0, b};
            end
            return wide[VALUE_W-1:0];
        end
    endfunction

    // Step a zero-based table index round the table
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        begin
            return (i >= LAST_IDX) ? '0 : i + 6'd1;
        end
    endfunction

    // Step a one-based position, wrapping past the last entry to 1
    function automatic logic [IDX_W-1:0] pos_inc(input logic [IDX_W-1:0] p);
        begin
            return (p >= 6'(TABLE_LEN)) ? 6'd1 : p + 6'd1;
        end
    endfunction

endpackage

/* src/srg_sequencer.sv */
// Step counter of the generator: fetches a control word from the program in
// srg_pkg and picks the next step from the datapath status. Uses srg_pkg.
module srg_sequencer import srg_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t upc_reg;
    step_t upc_next;
    logic  take;

    // Fetch the current control word
    always_comb begin
        ctrl = ucode_word(upc_reg);
    end

    // Evaluate the jump condition and choose the next step
    always_comb begin
        case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !status.accept;
            C_NO_RESEED: take = !status.reseed;
            C_CNT_NZ:    take = status.cnt_nz;
            C_OUT_BUSY:  take = status.out_busy;
            default:     take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : step_t'(upc_reg + 4'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* src/srg_datapath.sv */
// Datapath of the generator: lag table memory, scatter and warm-up registers,
// draw pointers and the output word register. Uses srg_pkg.
module srg_datapath import srg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_t                ctrl,
    output status_t              status,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [28:0]   s_seed,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [29:0]          m_draw_value,
    output logic                 m_was_reseeded
);

    logic [VALUE_W-1:0] mem [0:TABLE_LEN-1];

    logic               accept;
    logic               seed_neg;
    logic [SEED_W-1:0]  seed_mag;
    logic [SEED_W-1:0]  start_word;

    logic [SEED_W-1:0]  mag_reg,    mag_next;
    logic               reseed_reg, reseed_next;
    logic               init_reg,   init_next;
    logic [VALUE_W-1:0] cur_reg,    cur_next;
    logic [VALUE_W-1:0] prev_reg,   prev_next;
    logic [IDX_W-1:0]   ia_reg,     ia_next;
    logic [IDX_W-1:0]   ib_reg,     ib_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [IDX_W-1:0]   rp_reg,     rp_next;
    logic [IDX_W-1:0]   lp_reg,     lp_next;
    logic [VALUE_W-1:0] rda_reg;
    logic [VALUE_W-1:0] rdb_reg;
    logic               mv_reg,     mv_next;
    logic [VALUE_W-1:0] val_reg,    val_next;
    logic               resd_reg,   resd_next;

    logic               rd_en;
    logic [IDX_W-1:0]   raddr_a;
    logic [IDX_W-1:0]   raddr_b;
    logic               wr_en;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [VALUE_W-1:0] diff;
    logic [IDX_W:0]     scat_sum;

    assign s_ready  = (ctrl.op == OP_ACCEPT);
    assign accept   = s_valid && s_ready;
    assign seed_neg = s_seed[SEED_W-1];
    assign seed_mag = seed_neg ? (~s_seed + 29'd1) : s_seed;

    // Start word of the scatter: distance of the magnitude from the base
    assign start_word = (mag_reg > SEED_BASE) ? (mag_reg - SEED_BASE) : (SEED_BASE - mag_reg);

    assign diff     = sub_mod(rda_reg, rdb_reg);
    assign scat_sum = {1'b0, ia_reg} + {1'b0, STRIDE};

    assign status.accept   = accept;
    assign status.reseed   = reseed_reg;
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.out_busy = mv_reg && !m_ready;

    // Decode the control word into register updates and memory accesses
    always_comb begin
        mag_next    = mag_reg;
        reseed_next = reseed_reg;
        init_next   = init_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        cnt_next    = cnt_reg;
        rp_next     = rp_reg;
        lp_next     = lp_reg;
        val_next    = val_reg;
        resd_next   = resd_reg;
        mv_next     = mv_reg && !m_ready;
        rd_en       = 1'b0;
        raddr_a     = ia_reg;
        raddr_b     = ib_reg;
        wr_en       = 1'b0;
        waddr       = ia_reg;
        wdata       = diff;
        case (ctrl.op)
            OP_ACCEPT: begin
                if (accept) begin
                    mag_next    = seed_mag;
                    reseed_next = seed_neg || !init_reg;
                end
            end
            OP_SCAT_INIT: begin
                wr_en     = 1'b1;
                waddr     = LAST_IDX;
                wdata     = {1'b0, start_word};
                cur_next  = {1'b0, start_word};
                prev_next = 30'd1;
                ia_next   = STRIDE - 6'd1;
                cnt_next  = SCAT_LAST;
            end
            OP_SCAT: begin
                // Drop prev at the scattered slot and shift the pair along
                wr_en     = 1'b1;
                waddr     = ia_reg;
                wdata     = prev_reg;
                cur_next  = prev_reg;
                prev_next = sub_mod(cur_reg, prev_reg);
                ia_next   = (scat_sum >= 7'(TABLE_LEN)) ? 6'(scat_sum - 7'(TABLE_LEN))
                                                        : scat_sum[IDX_W-1:0];
                cnt_next  = cnt_reg - 8'd1;
            end
            OP_WARM_INIT: begin
                ia_next  = '0;
                ib_next  = LAG_START;
                cnt_next = WARM_LAST;
            end
            OP_WARM_RD: begin
                rd_en = 1'b1;
            end
            OP_WARM_WR: begin
                wr_en    = 1'b1;
                waddr    = ia_reg;
                wdata    = diff;
                ia_next  = idx_inc(ia_reg);
                ib_next  = idx_inc(ib_reg);
                cnt_next = cnt_reg - 8'd1;
            end
            OP_RESEED_END: begin
                rp_next   = '0;
                lp_next   = LAG_START;
                init_next = 1'b1;
            end
            OP_DRAW_ADV: begin
                rp_next = pos_inc(rp_reg);
                lp_next = pos_inc(lp_reg);
            end
            OP_DRAW_RD: begin
                rd_en   = 1'b1;
                raddr_a = rp_reg - 6'd1;
                raddr_b = lp_reg - 6'd1;
            end
            OP_DRAW_WR: begin
                wr_en     = 1'b1;
                waddr     = rp_reg - 6'd1;
                wdata     = diff;
                val_next  = diff;
                resd_next = reseed_reg;
                mv_next   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Lag table: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rda_reg <= mem[raddr_a];
            rdb_reg <= mem[raddr_b];
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        ia_reg     <= ia_next;
        ib_reg     <= ib_next;
        val_reg    <= val_next;
        resd_reg   <= resd_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reseed_reg <= 1'b0;
            init_reg   <= 1'b0;
            cnt_reg    <= '0;
            rp_reg     <= '0;
            lp_reg     <= LAG_START;
            mv_reg     <= 1'b0;
        end else begin
            reseed_reg <= reseed_next;
            init_reg   <= init_next;
            cnt_reg    <= cnt_next;
            rp_reg     <= rp_next;
            lp_reg     <= lp_next;
            mv_reg     <= mv_next;
        end
    end

    assign m_valid        = mv_reg;
    assign m_draw_value   = val_reg;
    assign m_was_reseeded = resd_reg;

endmodule

/* src/subtractive_random_generator.sv */
// Top level of the subtractive lagged Fibonacci generator: sequencer plus
// datapath. Depends on srg_pkg, srg_sequencer and srg_datapath.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  s_seed (29 bits, signed)
//   m_       out  m_valid / m_ready  m_draw_value (30 bits), m_was_reseeded
//
// A plain draw passes from acceptance through the check, pointer advance,
// table read, output wait and table write steps, the last loading the output
// word. A reseed adds 55 scatter writes and 220 warm-up updates, each
// update a read step and a write step on the lag table memory.
// Reset (aresetn low at a clock edge) clears the step counter, the flags and
// output valid and resets the pointers; the first draw after reset always reseeds.
// A new word is taken while a result still waits in the output register;
// a stalled output holds the sequencer before the next table write.
module subtractive_random_generator import srg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [28:0]  s_seed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [29:0]         m_draw_value,
    output logic                m_was_reseeded
);

    ctrl_t   ctrl;
    status_t status;

    srg_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    srg_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .status         (status),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_seed         (s_seed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_draw_value   (m_draw_value),
        .m_was_reseeded (m_was_reseeded)
    );

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DRAW_WR) |-> !(m_valid && !m_ready))
        else $error("output word overwritten while stalled");

    // An accepted word moves the sequencer off the wait step
    a_accept_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    // Results stay below one billion
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_draw_value < MOD_BIG))
        else $error("draw value out of range");

endmodule
